### sv/lsfd_pkg.sv
// shared types and constants for the level sensor filter and debounce unit
// no dependencies; imported by every module of the block

package lsfd_pkg;

  // fixed field widths
  localparam int LIM_W   = 12;  // level limits and divider denominator
  localparam int DELAY_W = 8;   // debounce delay and change counter
  localparam int PCT_W   = 7;   // level percent
  localparam int STEP_W  = 5;   // divider step counter, covers up to 31 quotient bits
  localparam int NUM2_W  = LIM_W + PCT_W;  // 100 * (average - low)
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = 2'd2;

  // register reset values
  localparam logic [LIM_W-1:0]   LEVEL_LOW_RST      = 12'd500;
  localparam logic [LIM_W-1:0]   LEVEL_HIGH_RST     = 12'd3500;
  localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RST = 8'd10;

  // arithmetic constants
  localparam logic [LIM_W-1:0]  AVG_DIVISOR = 12'd20;   // 19/20 blend
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_ZERO    = 7'd0;
  localparam logic [STEP_W-1:0] PCT_QBITS   = 5'd7;     // percent quotient never exceeds 100

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/lsfd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on lsfd_pkg for the control and status structs

module lsfd_div #(
  parameter int Q_W = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lsfd_pkg::div_ctrl_t       ctrl,
  input  logic [lsfd_pkg::LIM_W-1:0] num_hi,
  input  logic [Q_W-1:0]            num_lo,
  input  logic [lsfd_pkg::LIM_W-1:0] den,
  output lsfd_pkg::div_stat_t       stat,
  output logic [Q_W-1:0]            quot
);
  import lsfd_pkg::*;

  logic [LIM_W-1:0]  rem;
  logic [LIM_W-1:0]  den_q;
  logic [Q_W-1:0]    sh;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [LIM_W:0]    wide;
  logic [LIM_W+1:0]  trial;
  logic              qbit;

  // partial remainder stays below the divisor, so one more bit fits in LIM_W+1
  assign wide  = {rem, sh[Q_W-1]};
  assign trial = {1'b0, wide} - {2'b00, den_q};
  assign qbit  = ~trial[LIM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem   <= num_hi;
      sh    <= num_lo;
      den_q <= den;
    end else if (busy) begin
      rem <= qbit ? trial[LIM_W-1:0] : wide[LIM_W-1:0];
      sh  <= {sh[Q_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = sh;

  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero step count");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

### sv/lsfd_debounce.sv
// float switch debounce: saturating count of samples that differ from the held state
// depends on lsfd_pkg for widths

module lsfd_debounce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        sw,
  input  logic [lsfd_pkg::DELAY_W-1:0] delay,
  output logic                        state
);
  import lsfd_pkg::*;

  logic [DELAY_W-1:0] count;
  logic [DELAY_W-1:0] count_next;

  always_comb begin
    if (sw != state) begin
      count_next = (count == {DELAY_W{1'b1}}) ? count : count + 1'b1;
    end else begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      state <= 1'b0;
    end else if (en) begin
      count <= count_next;
      if (count_next > delay) begin
        state <= sw;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(state))
    else $error("switch state moved without a sample");

endmodule

### sv/level_sensor_filter_debounce_unit.sv
// level sensor filter and float switch debounce, top level
// depends on lsfd_pkg, lsfd_div and lsfd_debounce
//
// Usage: one request on the input channel (sample, probe_absent, switch_raw)
// gives exactly one result on the output channel (status, level_percent,
// switch_state, level_average). Both channels move a request at a rising
// edge with valid high and stall low. The configuration channel writes
// level_low, level_high or debounce_delay by index whenever valid is high;
// ready is always high. Write configuration only while the block is idle.
// The path from accept to the result register depends on the request: when
// the percent is divided out, one shared bit-serial divider runs SAMPLE_BITS
// steps for the 19/20 average and 7 for the percent; when the average is
// outside or on equal limits, only the average is divided; a probe-absent
// request goes straight to the result. One request is in work at a time and
// in_stall is high from accept until the result is handed to the output
// register, so a new request is not taken before the last result is loaded.
// The output register holds a result while out_stall is high; the next
// request may be accepted and worked meanwhile, then waits to be loaded.
// Reset (synchronous, active high) clears the average, switch state, change
// counter and percent, restores register defaults and drops out_valid.

module level_sensor_filter_debounce_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          probe_absent,
  input  logic                          switch_raw,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [lsfd_pkg::PCT_W-1:0]    level_percent,
  output logic                          switch_state,
  output logic [SAMPLE_BITS-1:0]        level_average,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsfd_pkg::LIM_W-1:0]    cfg_data
);
  import lsfd_pkg::*;

  localparam int NUM1_W = SAMPLE_BITS + 5;  // 19 * average + sample
  localparam int CMP_W  = (SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AVG  = 3'd1;
  localparam logic [2:0] ST_PCT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state;
  logic [LIM_W-1:0]       level_low;
  logic [LIM_W-1:0]       level_high;
  logic [DELAY_W-1:0]     debounce_delay;
  logic [SAMPLE_BITS-1:0] running_average;
  logic [PCT_W-1:0]       last_percent;
  logic                   stat_q;
  logic                   accepted_switch;

  logic                   in_acc;
  logic                   good_acc;
  logic                   out_load;

  logic [NUM1_W-1:0]      num1;
  logic [CMP_W-1:0]       avg_c;
  logic [CMP_W-1:0]       low_c;
  logic [CMP_W-1:0]       high_c;
  logic [LIM_W-1:0]       span;
  logic [LIM_W-1:0]       diff;
  logic [NUM2_W-1:0]      num2;
  logic                   below;
  logic                   above;
  logic                   pct_div;

  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [LIM_W-1:0]       div_hi;
  logic [SAMPLE_BITS-1:0] div_lo;
  logic [LIM_W-1:0]       div_den;
  logic [SAMPLE_BITS-1:0] div_quot;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign good_acc  = in_acc && !probe_absent;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  // 19*avg = 16*avg + 2*avg + avg
  assign num1 = NUM1_W'({running_average, 4'b0000}) + NUM1_W'({running_average, 1'b0})
              + NUM1_W'(running_average) + NUM1_W'(sample);

  assign avg_c  = CMP_W'(running_average);
  assign low_c  = CMP_W'(level_low);
  assign high_c = CMP_W'(level_high);
  assign below  = avg_c < low_c;
  assign above  = avg_c > high_c;
  assign span   = level_high - level_low;
  // average sits between the limits here, so the difference fits the limit width
  assign diff   = LIM_W'(avg_c - low_c);
  // 100*diff = 64*diff + 32*diff + 4*diff
  assign num2   = NUM2_W'({diff, 6'b000000}) + NUM2_W'({diff, 5'b00000})
                + NUM2_W'({diff, 2'b00});
  assign pct_div = !below && !above && (span != '0);

  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.steps = STEP_W'(SAMPLE_BITS);
    div_hi         = LIM_W'(num1[NUM1_W-1:SAMPLE_BITS]);
    div_lo         = num1[SAMPLE_BITS-1:0];
    div_den        = AVG_DIVISOR;
    if (state == ST_IDLE) begin
      div_ctrl.start = good_acc;
    end else begin
      div_ctrl.start = (state == ST_PCT) && pct_div;
      div_ctrl.steps = PCT_QBITS;
      div_hi         = num2[NUM2_W-1:PCT_W];
      div_lo         = {num2[PCT_W-1:0], {(SAMPLE_BITS-PCT_W){1'b0}}};
      div_den        = span;
    end
  end

  lsfd_div #(
    .Q_W(SAMPLE_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (div_ctrl),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .stat   (div_stat),
    .quot   (div_quot)
  );

  lsfd_debounce u_debounce (
    .clk   (clk),
    .rst   (rst),
    .en    (good_acc),
    .sw    (switch_raw),
    .delay (debounce_delay),
    .state (accepted_switch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level_low      <= LEVEL_LOW_RST;
      level_high     <= LEVEL_HIGH_RST;
      debounce_delay <= DEBOUNCE_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL_LOW:      level_low      <= cfg_data;
        REG_LEVEL_HIGH:     level_high     <= cfg_data;
        REG_DEBOUNCE_DELAY: debounce_delay <= cfg_data[DELAY_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      running_average <= '0;
      last_percent    <= PCT_ZERO;
      stat_q          <= STATUS_OK;
      out_valid       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            stat_q <= probe_absent ? STATUS_ABSENT : STATUS_OK;
            state  <= probe_absent ? ST_FIN : ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_stat.done) begin
            running_average <= div_quot;
            state           <= ST_PCT;
          end
        end
        ST_PCT: begin
          if (below) begin
            last_percent <= PCT_ZERO;
            state        <= ST_FIN;
          end else if (!pct_div) begin
            // above the high limit, or limits equal
            last_percent <= PCT_FULL;
            state        <= ST_FIN;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            last_percent <= div_quot[PCT_W-1:0];
            state        <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= stat_q;
      level_percent <= last_percent;
      switch_state  <= accepted_switch;
      level_average <= running_average;
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst) last_percent <= PCT_FULL)
    else $error("percent above full scale");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
      div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
